[sv/scbp_pkg.sv]
// Package for the size-class buffer pool: constants, beat types and helper functions.
`timescale 1ns / 1ps

package scbp_pkg;

    // Pool geometry, fixed by the widths of the beat fields.
    localparam int POOL_BUFFERS = 1024;
    localparam int SIZE_CLASSES = 32;
    localparam int LENGTH_BITS  = 24;

    localparam int HANDLE_W = 10;
    localparam int CLASS_W  = 5;
    localparam int CNT_W    = 16;
    localparam int FRESH_W  = $clog2(POOL_BUFFERS + 1);
    localparam int USABLE_W = 25;
    localparam int TOTAL_W  = 32;
    localparam int LINK_W   = HANDLE_W + 1;

    localparam logic [CNT_W-1:0] PERMANENT = 16'hFFFF;
    localparam int HEADER_ROUND = 15;
    localparam int MIN_CLASS    = 4;
    localparam int HEADER_BYTES = 16;

    // Job queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Operation codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RETAIN  = 2'd2;
    localparam logic [1:0] OP_RESIZE  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [1:0] ST_ZERO_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]             operation;
        logic [LENGTH_BITS-1:0] request_length;
        logic [HANDLE_W-1:0]    handle;
    } t_in_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [USABLE_W-1:0] usable_bytes;
        logic [CNT_W-1:0]    reference_count;
        logic                recycled;
        logic [TOTAL_W-1:0]  total_bytes;
        logic [1:0]          status;
    } t_out_item;

    // A classified request as it waits in the queue.
    typedef struct packed {
        logic [1:0]             op;
        logic [LENGTH_BITS-1:0] len;
        logic [HANDLE_W-1:0]    handle;
        logic [CLASS_W-1:0]     cls;
    } t_job;

    // Usable bytes of a buffer of the given class, after its header.
    function automatic logic [USABLE_W-1:0] usable_of(input logic [CLASS_W-1:0] cls);
        logic [TOTAL_W-1:0] p;
        p = TOTAL_W'(1) << cls;
        return USABLE_W'(p - TOTAL_W'(HEADER_BYTES));
    endfunction

endpackage

[sv/scbp_front.sv]
// Front end: takes request beats and tags each with its size class.
`timescale 1ns / 1ps

module scbp_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  scbp_pkg::t_in_item i_in_item,
    input  logic              i_full,
    output logic              o_push,
    output scbp_pkg::t_job    o_job
);
    import scbp_pkg::*;

    localparam int SUM_W = LENGTH_BITS + 1;
    localparam int L_W   = SUM_W - 4;

    logic [SUM_W-1:0]   w_sum;
    logic [L_W-1:0]     w_l;
    logic [CLASS_W-1:0] w_blen;

    // Round the length up to whole 16-byte units.
    assign w_sum = {1'b0, i_in_item.request_length} + SUM_W'(HEADER_ROUND);
    assign w_l   = w_sum[SUM_W-1:4];

    // Bit length of the unit count picks the power-of-two class.
    always_comb begin
        w_blen = '0;
        for (int i = 0; i < L_W; i++) begin
            if (w_l[i]) begin
                w_blen = CLASS_W'(i + 1);
            end
        end
    end

    assign o_job.op     = i_in_item.operation;
    assign o_job.len    = i_in_item.request_length;
    assign o_job.handle = i_in_item.handle;
    assign o_job.cls    = CLASS_W'(MIN_CLASS) + w_blen;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

[sv/scbp_queue.sv]
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module scbp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scbp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output scbp_pkg::t_job o_head,
    output logic           o_empty
);
    import scbp_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[sv/scbp_back.sv]
// Back end: sequences the buffer tables and free lists for one job at a time.
`timescale 1ns / 1ps

module scbp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scbp_pkg::t_job     i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scbp_pkg::t_out_item o_out_item
);
    import scbp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_RELOLD = 3'd4;

    // Buffer tables. Counts at or above the fill mark read as zero.
    logic [CNT_W-1:0]   r_ref_mem  [POOL_BUFFERS];
    logic [CLASS_W-1:0] r_cls_mem  [POOL_BUFFERS];
    logic [LINK_W-1:0]  r_link_mem [POOL_BUFFERS];

    // Free list heads.
    logic [SIZE_CLASSES-1:0] r_fh_v;
    logic [HANDLE_W-1:0]     r_fh_h [SIZE_CLASSES];

    logic [2:0]          r_state, n_state;
    t_job                r_job, n_job;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CLASS_W-1:0]  r_scls, n_scls;
    logic [HANDLE_W-1:0] r_new_h, n_new_h;
    logic                r_new_rec, n_new_rec;
    logic [FRESH_W-1:0]  r_fresh, n_fresh;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [CNT_W-1:0]    r_cnt_rd;
    logic [CLASS_W-1:0]  r_cls_rd;
    logic [LINK_W-1:0]   r_link_rd;

    logic                w_go;
    logic [CLASS_W-1:0]  w_fh_idx;
    logic                w_fh_v;
    logic [HANDLE_W-1:0] w_fh_h;
    logic [CNT_W-1:0]    w_cnt_eff;

    logic                w_emit;
    t_out_item           w_emit_item;
    logic                w_ref_we, w_cls_we, w_link_we, w_link_re, w_fh_we;
    logic [HANDLE_W-1:0] w_ref_wa, w_link_wa, w_fh_wh;
    logic [CNT_W-1:0]    w_ref_wd;
    logic [CLASS_W-1:0]  w_cls_wd;
    logic [LINK_W-1:0]   w_link_wd;
    logic [CLASS_W-1:0]  w_fh_wi;

    // Past idle, the back end advances only when the result register can take a beat.
    assign w_go = !r_out_valid || i_out_ready;

    // One free list head is looked at per cycle.
    always_comb begin
        case (r_state)
            S_EXEC:   w_fh_idx = r_cls_rd;
            S_RELOLD: w_fh_idx = r_scls;
            default:  w_fh_idx = r_job.cls;
        endcase
    end
    assign w_fh_v = r_fh_v[w_fh_idx];
    assign w_fh_h = r_fh_h[w_fh_idx];

    // Handles never handed out still hold a count of zero.
    assign w_cnt_eff = ({1'b0, r_job.handle} < r_fresh) ? r_cnt_rd : '0;

    // Job sequencer.
    always_comb begin
        logic [CNT_W-1:0]    v_cnt;
        logic [CNT_W-1:0]    v_new;
        logic [HANDLE_W-1:0] v_h;

        n_state     = r_state;
        n_job       = r_job;
        n_cnt       = r_cnt;
        n_scls      = r_scls;
        n_new_h     = r_new_h;
        n_new_rec   = r_new_rec;
        n_fresh     = r_fresh;
        n_total     = r_total;
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_emit_item = '0;
        w_ref_we    = 1'b0;
        w_ref_wa    = r_job.handle;
        w_ref_wd    = '0;
        w_cls_we    = 1'b0;
        w_cls_wd    = r_job.cls;
        w_link_we   = 1'b0;
        w_link_wa   = r_job.handle;
        w_link_wd   = {w_fh_v, w_fh_h};
        w_link_re   = 1'b0;
        w_fh_we     = 1'b0;
        w_fh_wi     = w_fh_idx;
        w_fh_wh     = r_job.handle;
        v_cnt       = '0;
        v_new       = '0;
        v_h         = '0;

        if (r_state == S_IDLE) begin
            if (!i_empty) begin
                o_pop   = 1'b1;
                n_job   = i_head;
                n_state = (i_head.op == OP_ALLOC) ? S_ALLOC : S_EXEC;
            end
        end else if (w_go) begin
            case (r_state)
                // Pop the class list, or hand out a fresh handle.
                S_ALLOC: begin
                    if (w_fh_v) begin
                        w_ref_we  = 1'b1;
                        w_ref_wa  = w_fh_h;
                        w_ref_wd  = CNT_W'(1);
                        w_cls_we  = 1'b1;
                        w_link_re = 1'b1;
                        n_new_h   = w_fh_h;
                        n_new_rec = 1'b1;
                        n_state   = S_LINK;
                    end else if (r_fresh == FRESH_W'(POOL_BUFFERS)) begin
                        w_emit      = 1'b1;
                        w_emit_item = '{result_handle: '0, usable_bytes: '0,
                                        reference_count: '0, recycled: 1'b0,
                                        total_bytes: r_total, status: ST_EXHAUSTED};
                        n_state     = S_IDLE;
                    end else begin
                        v_h       = r_fresh[HANDLE_W-1:0];
                        w_ref_we  = 1'b1;
                        w_ref_wa  = v_h;
                        w_ref_wd  = CNT_W'(1);
                        w_cls_we  = 1'b1;
                        n_fresh   = r_fresh + 1'b1;
                        n_total   = r_total + (TOTAL_W'(1) << r_job.cls);
                        n_new_h   = v_h;
                        n_new_rec = 1'b0;
                        if (r_job.op == OP_RESIZE) begin
                            n_state = S_RELOLD;
                        end else begin
                            w_emit      = 1'b1;
                            w_emit_item = '{result_handle: v_h,
                                            usable_bytes: usable_of(r_job.cls),
                                            reference_count: CNT_W'(1), recycled: 1'b0,
                                            total_bytes: n_total, status: ST_OK};
                            n_state     = S_IDLE;
                        end
                    end
                end
                // The popped handle's link becomes the new list head.
                S_LINK: begin
                    w_fh_we = 1'b1;
                    if (r_job.op == OP_RESIZE) begin
                        n_state = S_RELOLD;
                    end else begin
                        w_emit      = 1'b1;
                        w_emit_item = '{result_handle: r_new_h,
                                        usable_bytes: usable_of(r_job.cls),
                                        reference_count: CNT_W'(1), recycled: 1'b1,
                                        total_bytes: r_total, status: ST_OK};
                        n_state     = S_IDLE;
                    end
                end
                // Release, retain and resize of an existing handle.
                S_EXEC: begin
                    v_cnt   = w_cnt_eff;
                    n_state = S_IDLE;
                    if (v_cnt == '0) begin
                        w_emit      = 1'b1;
                        w_emit_item = '{result_handle: r_job.handle, usable_bytes: '0,
                                        reference_count: '0, recycled: 1'b0,
                                        total_bytes: r_total, status: ST_ZERO_COUNT};
                    end else begin
                        case (r_job.op)
                            OP_RELEASE: begin
                                v_new = v_cnt;
                                if (v_cnt != PERMANENT) begin
                                    v_new    = v_cnt - 1'b1;
                                    w_ref_we = 1'b1;
                                    w_ref_wd = v_new;
                                    if (v_new == '0) begin
                                        w_link_we = 1'b1;
                                        w_fh_we   = 1'b1;
                                    end
                                end
                                w_emit      = 1'b1;
                                w_emit_item = '{result_handle: r_job.handle,
                                                usable_bytes: usable_of(r_cls_rd),
                                                reference_count: v_new, recycled: 1'b0,
                                                total_bytes: r_total, status: ST_OK};
                            end
                            OP_RETAIN: begin
                                v_new       = (v_cnt == PERMANENT) ? v_cnt : v_cnt + 1'b1;
                                w_ref_we    = 1'b1;
                                w_ref_wd    = v_new;
                                w_emit      = 1'b1;
                                w_emit_item = '{result_handle: r_job.handle,
                                                usable_bytes: usable_of(r_cls_rd),
                                                reference_count: v_new, recycled: 1'b0,
                                                total_bytes: r_total, status: ST_OK};
                            end
                            OP_RESIZE: begin
                                if ({1'b0, r_job.len} <= usable_of(r_cls_rd)) begin
                                    w_emit      = 1'b1;
                                    w_emit_item = '{result_handle: r_job.handle,
                                                    usable_bytes: usable_of(r_cls_rd),
                                                    reference_count: v_cnt, recycled: 1'b0,
                                                    total_bytes: r_total, status: ST_OK};
                                end else begin
                                    n_cnt   = v_cnt;
                                    n_scls  = r_cls_rd;
                                    n_state = S_ALLOC;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
                // Resize moved: drop the old buffer and report the new one.
                S_RELOLD: begin
                    if (r_cnt != PERMANENT) begin
                        v_new    = r_cnt - 1'b1;
                        w_ref_we = 1'b1;
                        w_ref_wd = v_new;
                        if (v_new == '0) begin
                            w_link_we = 1'b1;
                            w_fh_we   = 1'b1;
                        end
                    end
                    w_emit      = 1'b1;
                    w_emit_item = '{result_handle: r_new_h,
                                    usable_bytes: usable_of(r_job.cls),
                                    reference_count: CNT_W'(1), recycled: r_new_rec,
                                    total_bytes: r_total, status: ST_OK};
                    n_state     = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Control registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_fh_v      <= '0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_total <= n_total;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fh_we) begin
                r_fh_v[w_fh_wi] <= (r_state == S_LINK) ? r_link_rd[LINK_W-1] : 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_cnt     <= n_cnt;
        r_scls    <= n_scls;
        r_new_h   <= n_new_h;
        r_new_rec <= n_new_rec;
        if (w_emit) begin
            r_out <= w_emit_item;
        end
        if (w_fh_we) begin
            r_fh_h[w_fh_wi] <= (r_state == S_LINK) ? r_link_rd[HANDLE_W-1:0] : w_fh_wh;
        end
    end

    // Buffer table memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (w_ref_we) begin
            r_ref_mem[w_ref_wa] <= w_ref_wd;
        end
        if (w_cls_we) begin
            r_cls_mem[w_ref_wa] <= w_cls_wd;
        end
        if (w_link_we) begin
            r_link_mem[w_link_wa] <= w_link_wd;
        end
        if (o_pop) begin
            r_cnt_rd <= r_ref_mem[i_head.handle];
            r_cls_rd <= r_cls_mem[i_head.handle];
        end
        if (w_link_re) begin
            r_link_rd <= r_link_mem[w_fh_h];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // A job is taken from the queue only when one is waiting.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("job popped from an empty queue");

    // The fresh handle mark never passes the pool size.
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= FRESH_W'(POOL_BUFFERS))
        else $error("fresh handle count beyond pool size");

    // The byte total moves only when a fresh handle is handed out.
    a_total_with_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fresh == $past(r_fresh)) |-> (r_total == $past(r_total)))
        else $error("byte total changed without a fresh allocation");

    // The sequencer leaves idle only by taking a job.
    a_idle_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !o_pop |=> (r_state == S_IDLE))
        else $error("sequencer started without a job");
`endif

endmodule

[sv/size_class_buffer_pool.sv]
// Top level of the size-class buffer pool: front end, job queue and back end.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Beat
// request   in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_ready  o_out_item (t_out_item)
//
// Release, retain, zero-count checks and a fitting resize run in S_EXEC;
// an allocate runs S_ALLOC, then S_LINK if recycled; a moving resize runs
// S_EXEC, S_ALLOC, S_LINK if recycled, then S_RELOLD, as the single-port
// buffer tables have registered reads. After reset no clearing pass runs;
// requests are taken on the next cycle. The queue takes requests while a result
// waits; the back end stalls past idle while the result register is full.
module size_class_buffer_pool (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  scbp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scbp_pkg::t_out_item o_out_item
);
    import scbp_pkg::*;

    logic w_push, w_full, w_pop, w_empty;
    t_job w_job, w_head;

    scbp_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    scbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    scbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
